FILE: rtl/core/fpra_pkg.sv
// shared types, constants and helper functions of the first piola residual accumulator
`default_nettype none
package fpra_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;

    localparam logic signed [ACC_W-1:0] SAT32_MAX = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] SAT32_MIN = -64'sd2147483648;

    typedef enum logic [1:0] {
        OP_LOAD_F = 2'd0,
        OP_LOAD_S = 2'd1,
        OP_TERM   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        DST_COF  = 4'b0001,
        DST_ROW  = 4'b0010,
        DST_DOT  = 4'b0100,
        DST_TERM = 4'b1000
    } dest_t;

    typedef struct packed {
        logic       act;
        dest_t      dest;
        logic       first;
        logic       last;
        logic       neg;
        logic [1:0] row_a;
        logic [1:0] col_a;
        logic [1:0] row_b;
        logic [1:0] col_b;
        logic [1:0] idx_i;
        logic [1:0] idx_j;
    } mul_cmd_t;

    typedef struct packed {
        mul_cmd_t mul;
        logic     emit;
    } dp_ctl_t;

    typedef struct packed {
        logic out_free;
        logic last;
    } dp_stat_t;

    function automatic logic [1:0] next_mod3(input logic [1:0] x);
        logic [1:0] r;
        r = (x == 2'd2) ? 2'd0 : x + 2'd1;
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > SAT32_MAX)
            r = SAT32_MAX[DATA_W-1:0];
        else if (x < SAT32_MIN)
            r = SAT32_MIN[DATA_W-1:0];
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/fpra_datapath.sv
// datapath: matrix stores, shared multiplier pipeline, accumulators and output register
`default_nettype none
module fpra_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [1:0]                            cfg_wdata,
    input  wire logic                                  in_accept,
    input  wire logic [1:0]                            opcode,
    input  wire logic [1:0]                            row_index,
    input  wire logic signed [fpra_pkg::DATA_W-1:0]    value_x,
    input  wire logic signed [fpra_pkg::DATA_W-1:0]    value_y,
    input  wire logic signed [fpra_pkg::DATA_W-1:0]    value_z,
    input  wire logic signed [fpra_pkg::DATA_W-1:0]    point_weight,
    input  wire logic                                  last_point,
    input  wire fpra_pkg::dp_ctl_t                     ctl,
    output fpra_pkg::dp_stat_t                         stat,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic signed [fpra_pkg::DATA_W-1:0]         residual_value,
    output logic                                       saturated
);

    localparam int DW = fpra_pkg::DATA_W;
    localparam int AW = fpra_pkg::ACC_W;

    logic [2:0][DW-1:0] f_mem [3];
    logic [2:0][DW-1:0] s_mem [3];
    logic [2:0][DW-1:0] f_rd_a_reg;
    logic [2:0][DW-1:0] f_rd_b_reg;
    logic [2:0][DW-1:0] s_rd_reg;

    logic [1:0] comp_reg;
    logic [1:0] comp_sel;

    logic signed [DW-1:0] grad_reg [3];
    logic signed [DW-1:0] weight_reg;
    logic                 last_reg;

    fpra_pkg::mul_cmd_t cmd1_reg;
    fpra_pkg::mul_cmd_t cmd2_reg;

    logic signed [DW-1:0] op_a;
    logic signed [DW-1:0] op_b;
    logic signed [AW-1:0] prod_next;
    logic signed [AW-1:0] prod_reg;

    logic signed [AW-1:0] shifted;
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] acc_reg;
    logic signed [DW-1:0] acc_sat;

    logic signed [DW-1:0] cof_reg [3][3];
    logic signed [DW-1:0] prow_reg [3];
    logic signed [DW-1:0] dot_reg;

    logic signed [AW:0]   sum_wide;
    logic signed [AW-1:0] res_next;
    logic signed [AW-1:0] res_reg;
    logic signed [DW-1:0] res_sat;

    logic                 out_valid_reg;
    logic signed [DW-1:0] out_value_reg;
    logic                 out_sat_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_reg <= 2'd0;
        end
        else if (cfg_we)
        begin
            comp_reg <= cfg_wdata;
        end
    end

    assign comp_sel = (comp_reg == 2'd3) ? 2'd2 : comp_reg;

    // matrix stores
    always_ff @(posedge clk)
    begin
        if (in_accept && (opcode == fpra_pkg::OP_LOAD_F) && (row_index != 2'd3))
        begin
            f_mem[row_index] <= {value_z, value_y, value_x};
        end
        if (in_accept && (opcode == fpra_pkg::OP_LOAD_S) && (row_index != 2'd3))
        begin
            s_mem[row_index] <= {value_z, value_y, value_x};
        end
        f_rd_a_reg <= f_mem[ctl.mul.row_a];
        f_rd_b_reg <= f_mem[ctl.mul.row_b];
        s_rd_reg   <= s_mem[comp_sel];
    end

    // term operands
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            grad_reg[0] <= value_x;
            grad_reg[1] <= value_y;
            grad_reg[2] <= value_z;
            weight_reg  <= point_weight;
            last_reg    <= last_point;
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd1_reg <= '0;
            cmd2_reg <= '0;
        end
        else
        begin
            cmd1_reg <= ctl.mul;
            cmd2_reg <= cmd1_reg;
        end
    end

    // operand select and multiply
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd1_reg.dest)
            fpra_pkg::DST_COF:
            begin
                op_a = f_rd_a_reg[cmd1_reg.col_a];
                op_b = f_rd_b_reg[cmd1_reg.col_b];
            end
            fpra_pkg::DST_ROW:
            begin
                op_a = s_rd_reg[cmd1_reg.idx_j];
                op_b = cof_reg[cmd1_reg.idx_j][cmd1_reg.idx_i];
            end
            fpra_pkg::DST_DOT:
            begin
                op_a = prow_reg[cmd1_reg.idx_j];
                op_b = grad_reg[cmd1_reg.idx_j];
            end
            fpra_pkg::DST_TERM:
            begin
                op_a = dot_reg;
                op_b = weight_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // shift, accumulate, write back
    assign shifted  = prod_reg >>> fpra_pkg::FRAC_BITS;
    assign addend   = cmd2_reg.neg ? -shifted : shifted;
    assign acc_next = (cmd2_reg.first ? '0 : acc_reg) + addend;
    assign acc_sat  = fpra_pkg::sat32(acc_next);

    assign sum_wide = {res_reg[AW-1], res_reg} + {shifted[AW-1], shifted};

    always_comb
    begin
        if (sum_wide[AW] != sum_wide[AW-1])
            res_next = sum_wide[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        else
            res_next = sum_wide[AW-1:0];
    end

    assign res_sat = fpra_pkg::sat32(res_reg);

    always_ff @(posedge clk)
    begin
        if (cmd2_reg.act)
        begin
            acc_reg <= acc_next;
        end
        if (cmd2_reg.act && cmd2_reg.last)
        begin
            case (cmd2_reg.dest)
                fpra_pkg::DST_COF:  cof_reg[cmd2_reg.idx_i][cmd2_reg.idx_j] <= acc_sat;
                fpra_pkg::DST_ROW:  prow_reg[cmd2_reg.idx_i] <= acc_sat;
                fpra_pkg::DST_DOT:  dot_reg <= acc_sat;
                default:            dot_reg <= dot_reg;
            endcase
        end
    end

    // residual sum and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.emit)
            begin
                res_reg <= '0;
            end
            else if (cmd2_reg.act && (cmd2_reg.dest == fpra_pkg::DST_TERM))
            begin
                res_reg <= res_next;
            end
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_value_reg <= res_sat;
            out_sat_reg   <= (AW'(res_sat) != res_reg);
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.last      = last_reg;
    assign out_valid      = out_valid_reg;
    assign residual_value = out_value_reg;
    assign saturated      = out_sat_reg;

endmodule
`default_nettype wire

FILE: rtl/core/fpra_controller.sv
// controller: sequences the multiply steps of one term transaction
`default_nettype none
module fpra_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [1:0]           opcode,
    output logic                      in_ready,
    output fpra_pkg::dp_ctl_t         ctl,
    input  wire fpra_pkg::dp_stat_t   stat
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_COF   = 7'b0000010,
        ST_ROW   = 7'b0000100,
        ST_DOT   = 7'b0001000,
        ST_TERM  = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    state_t     phase_reg, phase_next;
    logic [1:0] i_reg, i_next;
    logic [1:0] j_reg, j_next;
    logic       half_reg, half_next;
    logic       drain_reg, drain_next;

    logic [1:0] m1, m2, k1, k2;

    assign m1 = fpra_pkg::next_mod3(i_reg);
    assign m2 = fpra_pkg::next_mod3(m1);
    assign k1 = fpra_pkg::next_mod3(j_reg);
    assign k2 = fpra_pkg::next_mod3(k1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= ST_IDLE;
            i_reg     <= 2'd0;
            j_reg     <= 2'd0;
            half_reg  <= 1'b0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            half_reg  <= half_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        half_next  = half_reg;
        drain_next = drain_reg;
        in_ready   = 1'b0;
        ctl        = '0;
        ctl.mul.dest  = fpra_pkg::DST_COF;
        ctl.mul.idx_i = i_reg;
        ctl.mul.idx_j = j_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (opcode == fpra_pkg::OP_TERM))
                begin
                    state_next = ST_COF;
                    i_next     = 2'd0;
                    j_next     = 2'd0;
                    half_next  = 1'b0;
                end
            end
            ST_COF:
            begin
                ctl.mul.act   = 1'b1;
                ctl.mul.dest  = fpra_pkg::DST_COF;
                ctl.mul.row_a = m1;
                ctl.mul.row_b = m2;
                ctl.mul.first = !half_reg;
                ctl.mul.last  = half_reg;
                ctl.mul.neg   = half_reg;
                ctl.mul.col_a = half_reg ? k2 : k1;
                ctl.mul.col_b = half_reg ? k1 : k2;
                half_next = !half_reg;
                if (half_reg)
                begin
                    j_next = fpra_pkg::next_mod3(j_reg);
                    if (j_reg == 2'd2)
                    begin
                        i_next = fpra_pkg::next_mod3(i_reg);
                        if (i_reg == 2'd2)
                        begin
                            state_next = ST_DRAIN;
                            phase_next = ST_ROW;
                        end
                    end
                end
            end
            ST_ROW:
            begin
                ctl.mul.act   = 1'b1;
                ctl.mul.dest  = fpra_pkg::DST_ROW;
                ctl.mul.first = (j_reg == 2'd0);
                ctl.mul.last  = (j_reg == 2'd2);
                j_next = fpra_pkg::next_mod3(j_reg);
                if (j_reg == 2'd2)
                begin
                    i_next = fpra_pkg::next_mod3(i_reg);
                    if (i_reg == 2'd2)
                    begin
                        state_next = ST_DRAIN;
                        phase_next = ST_DOT;
                    end
                end
            end
            ST_DOT:
            begin
                ctl.mul.act   = 1'b1;
                ctl.mul.dest  = fpra_pkg::DST_DOT;
                ctl.mul.first = (j_reg == 2'd0);
                ctl.mul.last  = (j_reg == 2'd2);
                j_next = fpra_pkg::next_mod3(j_reg);
                if (j_reg == 2'd2)
                begin
                    state_next = ST_DRAIN;
                    phase_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                ctl.mul.act   = 1'b1;
                ctl.mul.dest  = fpra_pkg::DST_TERM;
                ctl.mul.first = 1'b1;
                ctl.mul.last  = 1'b1;
                state_next = ST_DRAIN;
                phase_next = ST_EMIT;
            end
            ST_DRAIN:
            begin
                drain_next = !drain_reg;
                if (drain_reg)
                begin
                    state_next = phase_reg;
                    i_next     = 2'd0;
                    j_next     = 2'd0;
                end
            end
            ST_EMIT:
            begin
                if (!stat.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/first_piola_residual_accumulator.sv
// top level of the first piola residual accumulator
//
// input channel: in_valid/in_ready with opcode, row_index, value_x/y/z, point_weight
// and last_point. a load transaction writes one row of the deformation or stress
// matrix. a term transaction forms one row of the first piola stress through the
// cofactor matrix, dots it with the gradient, scales by the weight and adds to
// the 64-bit residual sum.
// a term holds the block while one shared 32x32 multiplier runs 31 products
// (18 cofactor, 9 row, 3 dot, 1 weight), with drain states of its three-stage
// pipeline between dependent phases.
// output channel: out_valid/out_ready with residual_value and saturated, one
// transaction per term marked last; the sum is cleared when the result is
// loaded into the output register; a stalled receiver only holds the block
// when the next last term is ready to send.
// cfg_we/cfg_wdata write stress_component; the user must do so only while idle,
// the block does not enforce it. reset clears the residual sum, the output valid
// flag and all control; matrix stores are undefined until loaded.
`default_nettype none
module first_piola_residual_accumulator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [1:0]                          cfg_wdata,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          opcode,
    input  wire logic [1:0]                          row_index,
    input  wire logic signed [fpra_pkg::DATA_W-1:0]  value_x,
    input  wire logic signed [fpra_pkg::DATA_W-1:0]  value_y,
    input  wire logic signed [fpra_pkg::DATA_W-1:0]  value_z,
    input  wire logic signed [fpra_pkg::DATA_W-1:0]  point_weight,
    input  wire logic                                last_point,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [fpra_pkg::DATA_W-1:0]       residual_value,
    output logic                                     saturated
);

    fpra_pkg::dp_ctl_t  ctl;
    fpra_pkg::dp_stat_t stat;

    fpra_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .ctl      (ctl),
        .stat     (stat)
    );

    fpra_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_accept      (in_valid && in_ready),
        .opcode         (opcode),
        .row_index      (row_index),
        .value_x        (value_x),
        .value_y        (value_y),
        .value_z        (value_z),
        .point_weight   (point_weight),
        .last_point     (last_point),
        .ctl            (ctl),
        .stat           (stat),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .residual_value (residual_value),
        .saturated      (saturated)
    );

endmodule
`default_nettype wire

FILE: rtl/core/fpra_checker.sv
// port-level checker of the first piola residual accumulator and its bind
`default_nettype none
module fpra_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic [1:0]                          opcode,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic signed [fpra_pkg::DATA_W-1:0]  residual_value,
    input wire logic                                saturated
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(residual_value) && $stable(saturated))
        else $error("result changed while stalled");

    // clipped result sits at a bound
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (residual_value == 32'sh7fffffff) || (residual_value == 32'sh80000000))
        else $error("saturated result not at a bound");

    // a term transaction occupies the block
    a_term_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == fpra_pkg::OP_TERM) |=> !in_ready ##1 !in_ready)
        else $error("input taken during term processing");

    // results appear only while a term is in progress
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a term in progress");

endmodule

bind first_piola_residual_accumulator fpra_checker u_fpra_checker (.*);
`default_nettype wire
